// ----- rtl/rmf_pkg.sv -----
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int WINDOW_LEN  = 5;

    localparam int SENSOR_W   = 3;
    localparam int RAW_W      = 16;
    localparam int MM_W       = 14;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam logic [MM_W-1:0] INVALID_MM      = 14'd9999;
    localparam logic [MM_W-1:0] LIMIT_CAP       = 14'd9998;
    localparam logic [MM_W-1:0] MAX_VALID_RESET = 14'd2200;

    localparam int DEPTH    = NUM_SENSORS * WINDOW_LEN;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SIDX_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int MID_IDX  = (WINDOW_LEN - 1) / 2;

    typedef logic [MM_W-1:0] mm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VALID = 4'd0,
        REG_ENABLE    = 4'd1,
        REG_SHUTDOWN  = 4'd2,
        REG_MEDIAN    = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic fill;
        logic start;
        logic run;
    } rank_ctl_t;

    typedef struct packed {
        logic found;
        mm_t  median;
    } rank_st_t;

endpackage

// ----- rtl/range_median_filter.sv -----
`timescale 1ns / 1ps
// median mode off or ignored sensor: accept goes straight to S_DONE, then to the output
// window path: S_WRITE, S_READ of the window, S_FILL, S_START, then S_RANK ranks candidates
// until the median (1..WINDOW_LEN of them), then S_DONE; the single compare unit sets its length
// throughput: one item at a time, next taken after the result is registered; S_DONE may stall
// reset: config back to defaults, windows read as zero, ring positions zero, no item pending

module range_median_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // sensor_num, raw_mm
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // sensor_out, filtered_mm
    output logic                           m_tuser,   // updated
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rmf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_READ  = 7'b0000100,
        S_FILL  = 7'b0001000,
        S_START = 7'b0010000,
        S_RANK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg;
    mm_t                   max_valid_reg;
    logic [MASK_W-1:0]     enable_reg;
    logic                  shutdown_reg;
    logic                  median_reg;

    logic [SENSOR_W-1:0]   sensor_reg;
    mm_t                   q_reg;
    mm_t                   res_reg;
    logic                  upd_reg;
    logic [POS_W-1:0]      k_reg;
    logic                  rd_pend_reg;
    logic                  vld_d_reg;
    logic [POS_W-1:0]      pos_reg [NUM_SENSORS];
    logic [DEPTH-1:0]      valid_reg;

    logic                  m_tvalid_reg;
    logic [SENSOR_W-1:0]   out_sensor_reg;
    mm_t                   out_mm_reg;
    logic                  out_upd_reg;

    logic [SENSOR_W-1:0]   in_sensor;
    logic [RAW_W-1:0]      in_raw;
    mm_t                   limit;
    mm_t                   q_in;
    logic                  active;
    logic                  accept;
    logic                  out_free;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [POS_W-1:0]      cur_pos;
    logic [POS_W-1:0]      pos_next;
    mm_t                   rdata;
    mm_t                   fill_data;
    rank_ctl_t             rank_ctl;
    rank_st_t              rank_st;

    assign in_sensor = s_tdata[SENSOR_W-1:0];
    assign in_raw    = s_tdata[SENSOR_W+RAW_W-1:SENSOR_W];

    assign limit  = (max_valid_reg > LIMIT_CAP) ? LIMIT_CAP : max_valid_reg;
    assign q_in   = ((in_raw == '0) || (in_raw > RAW_W'(limit))) ? INVALID_MM
                                                                 : in_raw[MM_W-1:0];
    assign active = ({1'b0, in_sensor} < (SENSOR_W + 1)'(NUM_SENSORS))
                    && enable_reg[in_sensor]
                    && ((in_sensor == '0) || shutdown_reg);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign base     = ADDR_W'(sensor_reg) * ADDR_W'(WINDOW_LEN);
    assign cur_pos  = pos_reg[sensor_reg[SIDX_W-1:0]];
    assign pos_next = (cur_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : cur_pos + POS_W'(1);
    assign waddr    = base + ADDR_W'(cur_pos);
    assign raddr    = base + ADDR_W'(k_reg);

    // entries never written read as zero
    assign fill_data = vld_d_reg ? rdata : '0;

    assign rank_ctl.fill  = rd_pend_reg;
    assign rank_ctl.start = (state_reg == S_START);
    assign rank_ctl.run   = (state_reg == S_RANK);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_upd_reg;
    assign m_tdata  = {(24 - SENSOR_W - MM_W)'(0), out_mm_reg, out_sensor_reg};

    rmf_ram #(
        .WIDTH (MM_W),
        .DEPTH (DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (waddr),
        .wdata (q_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    rmf_rank u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rank_ctl),
        .fill_data (fill_data),
        .st        (rank_st)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_valid_reg <= MAX_VALID_RESET;
            enable_reg    <= '0;
            shutdown_reg  <= 1'b0;
            median_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_VALID: max_valid_reg <= cfg_data[MM_W-1:0];
                REG_ENABLE:    enable_reg    <= cfg_data[MASK_W-1:0];
                REG_SHUTDOWN:  shutdown_reg  <= cfg_data[0];
                REG_MEDIAN:    median_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            rd_pend_reg  <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_READ);
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (active && median_reg)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WRITE:
                begin
                    valid_reg[waddr]                  <= 1'b1;
                    pos_reg[sensor_reg[SIDX_W-1:0]] <= pos_next;
                    k_reg                             <= '0;
                    state_reg                         <= S_READ;
                end
                S_READ:
                begin
                    k_reg <= k_reg + POS_W'(1);
                    if (k_reg == POS_W'(WINDOW_LEN - 1))
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_RANK;
                end
                S_RANK:
                begin
                    if (rank_st.found)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        vld_d_reg <= valid_reg[raddr];
        if (accept)
        begin
            sensor_reg <= in_sensor;
            q_reg      <= q_in;
            upd_reg    <= active;
            res_reg    <= active ? q_in : '0;
        end
        if (rank_st.found)
        begin
            res_reg <= rank_st.median;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_sensor_reg <= sensor_reg;
            out_mm_reg     <= res_reg;
            out_upd_reg    <= upd_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[SENSOR_W+MM_W-1:SENSOR_W] == '0))
        else $error("ignored item carries a nonzero distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SENSOR_W+MM_W-1:SENSOR_W] <= INVALID_MM))
        else $error("distance above the invalid code");

    assert property (@(posedge clk) disable iff (!rst_n)
        rank_st.found |-> (state_reg == S_RANK))
        else $error("median found outside the ranking phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second item taken while one is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RANK) |-> !rd_pend_reg)
        else $error("window read still pending while ranking");

endmodule

// ----- rtl/rmf_ram.sv -----
`timescale 1ns / 1ps

module rmf_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 40
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rmf_rank.sv -----
`timescale 1ns / 1ps

module rmf_rank (
    input  logic              clk,
    input  logic              rst_n,
    input  rmf_pkg::rank_ctl_t ctl,
    input  rmf_pkg::mm_t       fill_data,
    output rmf_pkg::rank_st_t  st
);
    import rmf_pkg::*;

    mm_t              ring_reg [WINDOW_LEN];
    mm_t              cand_reg;
    logic [CNT_W-1:0] lt_reg;
    logic [CNT_W-1:0] le_reg;
    logic [POS_W-1:0] step_reg;

    logic [MM_W:0]    diff;
    logic             lt_hit;
    logic             le_hit;
    logic [CNT_W-1:0] lt_sum;
    logic [CNT_W-1:0] le_sum;
    logic             last_step;
    logic             is_med;

    // shared compare: window element against the candidate
    assign diff      = {1'b0, cand_reg} - {1'b0, ring_reg[0]};
    assign le_hit    = ~diff[MM_W];
    assign lt_hit    = ~diff[MM_W] && (diff[MM_W-1:0] != '0);
    assign lt_sum    = lt_reg + CNT_W'(lt_hit);
    assign le_sum    = le_reg + CNT_W'(le_hit);
    assign last_step = (step_reg == POS_W'(WINDOW_LEN - 1));
    assign is_med    = (lt_sum <= CNT_W'(MID_IDX)) && (le_sum >= CNT_W'(MID_IDX + 1));

    assign st.found  = ctl.run && last_step && is_med;
    assign st.median = cand_reg;

    // ring rotates by one between compares, so each pass starts on a new front element
    always_ff @(posedge clk)
    begin
        if (ctl.fill)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                ring_reg[i] <= ring_reg[i+1];
            end
            ring_reg[WINDOW_LEN-1] <= fill_data;
        end
        else if (ctl.run && !last_step)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= ring_reg[(i + 1) % WINDOW_LEN];
            end
        end

        if (ctl.start)
        begin
            cand_reg <= ring_reg[0];
        end
        else if (ctl.run && last_step)
        begin
            cand_reg <= ring_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg   <= '0;
            le_reg   <= '0;
            step_reg <= '0;
        end
        else if (ctl.start || (ctl.run && last_step))
        begin
            lt_reg   <= '0;
            le_reg   <= '0;
            step_reg <= '0;
        end
        else if (ctl.run)
        begin
            lt_reg   <= lt_sum;
            le_reg   <= le_sum;
            step_reg <= step_reg + POS_W'(1);
        end
    end

endmodule
